/* design/line_box_sum_replicate_macros.svh */
// Assertion macros shared by the checker
`ifndef LINE_BOX_SUM_REPLICATE_MACROS_SVH
`define LINE_BOX_SUM_REPLICATE_MACROS_SVH

// same-cycle implication
`define LBSR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lbsr_pkg.sv */
`default_nettype none
package lbsr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 22;
    localparam int SUM_W      = 23;
    localparam int RADIUS_W   = 5;
    localparam int RECIP_W    = 16;
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP     = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;
    localparam logic [RECIP_W-1:0]  RECIP_RESET  = 16'd21845;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                line_end;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_of_run;
        logic               line_done;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first;
        logic                use_first;
        logic                emit;
        logic                last_of_run;
        logic                line_done;
        logic [RADIUS_W-1:0] radius;
    } op_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last_of_run;
        logic             line_done;
    } res_t;

    typedef enum logic {
        SEQ_STREAM,
        SEQ_DRAIN
    } seq_state_t;

endpackage
`default_nettype wire

/* design/lbsr_ring.sv */
`default_nettype none
module lbsr_ring (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [lbsr_pkg::RING_AW-1:0]        wr_addr,
    input  logic [lbsr_pkg::SAMPLE_W-1:0]       wr_data,
    input  logic                                rd_en,
    input  logic [lbsr_pkg::RING_AW-1:0]        rd_addr,
    output logic [lbsr_pkg::SAMPLE_W-1:0]       rd_data
);
    import lbsr_pkg::*;

    logic [SAMPLE_W-1:0] mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* design/lbsr_front.sv */
`default_nettype none
module lbsr_front #(
    parameter int MAX_LINE = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lbsr_pkg::in_item_t                in_item,
    input  logic [lbsr_pkg::RADIUS_W-1:0]     radius,
    input  logic                              free,
    output logic                              op_valid,
    output lbsr_pkg::op_t                     op,
    output logic [lbsr_pkg::SAMPLE_W-1:0]     fetch
);
    import lbsr_pkg::*;

    localparam int PW = $clog2(MAX_LINE);
    localparam int IW = PW + 2;
    localparam logic [PW-1:0] LAST_POS = PW'(MAX_LINE - 1);

    seq_state_t          state_reg, state_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [RADIUS_W-1:0] line_r_reg, line_r_next;
    logic [SAMPLE_W-1:0] first_sample_reg, first_sample_next;
    logic [RADIUS_W-1:0] drain_cnt_reg, drain_cnt_next;
    logic [PW-1:0]       drain_k_reg, drain_k_next;
    logic [SAMPLE_W-1:0] drain_x_reg, drain_x_next;
    logic                op_valid_reg, op_valid_next;
    op_t                 op_reg, op_next;

    logic                s1_free;
    logic                accept;
    logic                drain_load;
    logic                at_first;
    logic                line_ends;
    logic [RADIUS_W-1:0] r_in;
    logic [IW-1:0]       idx_in;
    logic [IW-1:0]       idx_dr;
    logic [IW-1:0]       pos_dr;
    op_t                 in_op;
    op_t                 dr_op;
    logic                rd_en;
    logic [RING_AW-1:0]  rd_addr;
    logic [SAMPLE_W-1:0] rd_data;

    lbsr_ring u_ring (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (pos_reg[RING_AW-1:0]),
        .wr_data (in_item.sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_free    = !op_valid_reg || free;
        in_ready   = s1_free && (state_reg == SEQ_STREAM);
        accept     = in_valid && in_ready;
        drain_load = s1_free && (state_reg == SEQ_DRAIN);

        at_first  = (pos_reg == '0);
        r_in      = at_first ? radius : line_r_reg;
        line_ends = in_item.line_end || (pos_reg == LAST_POS);
        idx_in    = {2'b00, pos_reg} - {{(IW-RADIUS_W-1){1'b0}}, r_in, 1'b1};

        in_op.sample      = in_item.sample;
        in_op.first       = at_first;
        in_op.use_first   = idx_in[IW-1] || (idx_in == '0);
        in_op.emit        = pos_reg >= PW'(r_in);
        in_op.last_of_run = line_ends ? (r_in == '0) : (pos_reg >= PW'(r_in));
        in_op.line_done   = line_ends && (r_in == '0);
        in_op.radius      = r_in;

        idx_dr = {2'b00, drain_k_reg} - {{(IW-RADIUS_W-1){1'b0}}, line_r_reg, 1'b1}
               + {{(IW-RADIUS_W){1'b0}}, drain_cnt_reg};
        pos_dr = {2'b00, drain_k_reg} - {{(IW-RADIUS_W){1'b0}}, line_r_reg}
               + {{(IW-RADIUS_W){1'b0}}, drain_cnt_reg};

        dr_op.sample      = drain_x_reg;
        dr_op.first       = 1'b0;
        dr_op.use_first   = idx_dr[IW-1] || (idx_dr == '0);
        dr_op.emit        = !pos_dr[IW-1];
        dr_op.last_of_run = (drain_cnt_reg == line_r_reg);
        dr_op.line_done   = (drain_cnt_reg == line_r_reg);
        dr_op.radius      = line_r_reg;

        rd_en   = accept || drain_load;
        rd_addr = (state_reg == SEQ_DRAIN) ? idx_dr[RING_AW-1:0] : idx_in[RING_AW-1:0];

        state_next        = state_reg;
        pos_next          = pos_reg;
        line_r_next       = line_r_reg;
        first_sample_next = first_sample_reg;
        drain_cnt_next    = drain_cnt_reg;
        drain_k_next      = drain_k_reg;
        drain_x_next      = drain_x_reg;
        op_valid_next     = op_valid_reg;
        op_next           = op_reg;

        if (accept)
        begin
            pos_next = line_ends ? '0 : pos_reg + 1'b1;
            if (at_first)
            begin
                line_r_next       = radius;
                first_sample_next = in_item.sample;
            end
            if (line_ends && (r_in != '0))
            begin
                state_next     = SEQ_DRAIN;
                drain_cnt_next = RADIUS_W'(1);
                drain_k_next   = pos_reg;
                drain_x_next   = in_item.sample;
            end
        end

        if (drain_load)
        begin
            if (drain_cnt_reg == line_r_reg)
            begin
                state_next = SEQ_STREAM;
            end
            else
            begin
                drain_cnt_next = drain_cnt_reg + 1'b1;
            end
        end

        if (s1_free)
        begin
            op_valid_next = accept || drain_load;
            op_next       = (state_reg == SEQ_DRAIN) ? dr_op : in_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= SEQ_STREAM;
            pos_reg          <= '0;
            line_r_reg       <= RADIUS_RESET;
            first_sample_reg <= '0;
            drain_cnt_reg    <= '0;
            op_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            line_r_reg       <= line_r_next;
            first_sample_reg <= first_sample_next;
            drain_cnt_reg    <= drain_cnt_next;
            op_valid_reg     <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drain_k_reg <= drain_k_next;
        drain_x_reg <= drain_x_next;
        op_reg      <= op_next;
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;
    assign fetch    = op_reg.use_first ? first_sample_reg : rd_data;

endmodule
`default_nettype wire

/* design/lbsr_accum.sv */
`default_nettype none
module lbsr_accum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              op_valid,
    input  lbsr_pkg::op_t                     op,
    input  logic [lbsr_pkg::SAMPLE_W-1:0]     fetch,
    output logic                              free,
    input  logic                              take,
    output logic                              res_valid,
    output lbsr_pkg::res_t                    res
);
    import lbsr_pkg::*;

    logic [SUM_W-1:0]    running_sum_reg, running_sum_next;
    logic                res_valid_reg;
    logic                last_reg;
    logic                done_reg;
    logic [SUM_W-1:0]    prod;
    logic [RADIUS_W:0]   area;

    always_comb
    begin
        free = !res_valid_reg || take;
        area = {op.radius, 1'b1};
        prod = {{(SUM_W-RADIUS_W-1){1'b0}}, area} * {{(SUM_W-SAMPLE_W){1'b0}}, op.sample};
        running_sum_next = op.first ? prod
                         : running_sum_reg + {{(SUM_W-SAMPLE_W){1'b0}}, op.sample}
                           - {{(SUM_W-SAMPLE_W){1'b0}}, fetch};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else if (free)
        begin
            res_valid_reg <= op_valid && op.emit;
            if (op_valid)
            begin
                running_sum_reg <= running_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && op_valid)
        begin
            last_reg <= op.last_of_run;
            done_reg <= op.line_done;
        end
    end

    assign res_valid       = res_valid_reg;
    assign res.sum         = running_sum_reg;
    assign res.last_of_run = last_reg;
    assign res.line_done   = done_reg;

endmodule
`default_nettype wire

/* design/lbsr_norm.sv */
`default_nettype none
module lbsr_norm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_valid,
    input  lbsr_pkg::res_t                    res,
    input  logic                              normalize_enable,
    input  logic [lbsr_pkg::RECIP_W-1:0]      recip_scale,
    output logic                              take,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lbsr_pkg::out_item_t               out_item
);
    import lbsr_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (RECIP_W - 1);

    logic                   out_valid_reg;
    out_item_t              out_item_reg, out_item_next;
    logic [PROD_W-1:0]      product;
    logic [PROD_W:0]        rounded;

    always_comb
    begin
        take    = !out_valid_reg || out_ready;
        product = {{RECIP_W{1'b0}}, res.sum} * {{SUM_W{1'b0}}, recip_scale};
        rounded = {1'b0, product} + ROUND_HALF;
        out_item_next.value = normalize_enable ? rounded[RECIP_W+VALUE_W-1:RECIP_W]
                                               : res.sum[VALUE_W-1:0];
        out_item_next.last_of_run = res.last_of_run;
        out_item_next.line_done   = res.line_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

/* design/line_box_sum_replicate.sv */
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_item   (sample, line_end)
// out       out_valid / out_ready  out_item  (value, last_of_run, line_done)
// cfg       cfg_we                 cfg_index, cfg_data
//
// One sample request per cycle while in_ready is high.
// The last sample of a line with radius r holds in_ready low while the sequencer
// issues the remaining window sums, up to r of them, from the history ring.
// Reset is asynchronous; registers return to radius 1, no scaling, 21845.
// out_ready low stalls the three stages from the output back to in_ready.
`default_nettype none
module line_box_sum_replicate #(
    parameter int MAX_LINE = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lbsr_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lbsr_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [lbsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lbsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lbsr_pkg::*;

    logic [RADIUS_W-1:0] radius_reg;
    logic                normalize_reg;
    logic [RECIP_W-1:0]  recip_reg;

    logic                op_valid;
    op_t                 op;
    logic [SAMPLE_W-1:0] fetch;
    logic                free;
    logic                take;
    logic                res_valid;
    res_t                res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RADIUS_RESET;
            normalize_reg <= 1'b0;
            recip_reg     <= RECIP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS:    radius_reg    <= cfg_data[RADIUS_W-1:0];
                CFG_NORMALIZE: normalize_reg <= cfg_data[0];
                CFG_RECIP:     recip_reg     <= cfg_data[RECIP_W-1:0];
                default:       ;
            endcase
        end
    end

    lbsr_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .radius   (radius_reg),
        .free     (free),
        .op_valid (op_valid),
        .op       (op),
        .fetch    (fetch)
    );

    lbsr_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op),
        .fetch     (fetch),
        .free      (free),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    lbsr_norm u_norm (
        .clk              (clk),
        .rst_n            (rst_n),
        .res_valid        (res_valid),
        .res              (res),
        .normalize_enable (normalize_reg),
        .recip_scale      (recip_reg),
        .take             (take),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_item         (out_item)
    );

endmodule
`default_nettype wire

/* design/lbsr_checker.sv */
`default_nettype none
`include "line_box_sum_replicate_macros.svh"
module lbsr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  lbsr_pkg::out_item_t                 out_item
);
    import lbsr_pkg::*;

    `LBSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_item), "stalled result changed")

    `LBSR_ASSERT_NOW(a_done_is_last, clk, rst_n, out_valid && out_item.line_done,
        out_item.last_of_run, "line end result not marked last of run")

    `LBSR_ASSERT_NOW(a_quiet_after_reset, clk, rst_n, $rose(rst_n),
        !out_valid, "result shown straight after reset")

endmodule

bind line_box_sum_replicate lbsr_checker u_lbsr_checker (.*);
`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lbsr_pkg::*;

    localparam int LINE_LIMIT   = 4096;
    localparam int SETTLE_TICKS = 40;
    localparam int PHASE_ITEMS  = 14;
    localparam int LONG_ITEMS   = 70;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [RADIUS_W-1:0]   shadow_radius;
    logic                  shadow_norm;
    logic [RECIP_W-1:0]    shadow_recip;

    logic [SAMPLE_W-1:0]   line_history [RING_DEPTH];
    logic [SAMPLE_W-1:0]   edge_sample;
    logic [SUM_W-1:0]      window_total;
    int                    line_pos;
    int                    line_r;

    out_item_t             pending_sums [$];
    int                    fault_count;
    int                    burst_left;
    int                    ready_mode;
    int                    ready_left;

    line_box_sum_replicate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin : receiver_pattern
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(4, 60);
        end
        else
        begin
            ready_left--;
        end
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= ((ready_left % 4) == 0);
            default: out_ready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_sums.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: value %0d last %0b done %0b",
                             out_item.value, out_item.last_of_run, out_item.line_done);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (out_item.value !== want.value ||
                    out_item.last_of_run !== want.last_of_run ||
                    out_item.line_done !== want.line_done)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 want.value, want.last_of_run, want.line_done,
                                 out_item.value, out_item.last_of_run, out_item.line_done);
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] past_sample(int idx);
        if (idx <= 0)
            return edge_sample;
        return line_history[RING_AW'(idx % RING_DEPTH)];
    endfunction

    function automatic logic [VALUE_W-1:0] scaled_value(logic [SUM_W-1:0] total);
        logic [63:0] v;
        v = total;
        if (shadow_norm)
            v = (v * shadow_recip + 64'd32768) >> 16;
        return v[VALUE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic predict_window(input logic [SAMPLE_W-1:0] px, input logic eol);
        int        k;
        int        i;
        logic      at_end;
        out_item_t res;
        out_item_t batch [$];
        k = line_pos;
        at_end = eol || (k >= LINE_LIMIT - 1);
        if (k == 0)
        begin
            line_r = shadow_radius;
            edge_sample = px;
            window_total = SUM_W'((2 * line_r + 1) * px);
        end
        else
        begin
            window_total = window_total + px - past_sample(k - 2 * line_r - 1);
        end
        line_history[RING_AW'(k % RING_DEPTH)] = px;
        res = '0;
        if (k >= line_r)
        begin
            res.value = scaled_value(window_total);
            batch.push_back(res);
        end
        if (at_end)
        begin
            for (i = k - line_r + 1; i <= k; i++)
            begin
                window_total = window_total + px - past_sample(i - line_r - 1);
                if (i >= 0)
                begin
                    res.value = scaled_value(window_total);
                    batch.push_back(res);
                end
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].line_done = 1'b1;
            line_pos = 0;
        end
        else
        begin
            line_pos = k + 1;
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last_of_run = 1'b1;
        foreach (batch[n])
            pending_sums.push_back(batch[n]);
    endtask

    task automatic send_request(input logic [SAMPLE_W-1:0] px, input logic eol);
        int       gap;
        in_item_t req;
        req.sample = px;
        req.line_end = eol;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= req;
        // hold the request until accepted
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_window(px, eol);
        @(negedge clk);
    endtask

    task automatic send_line(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_request(pick_sample(), i == len - 1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_RADIUS:    shadow_radius = data[RADIUS_W-1:0];
            CFG_NORMALIZE: shadow_norm = data[0];
            CFG_RECIP:     shadow_recip = data[RECIP_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_reset_defaults();
        send_request(16'hFFFF, 1'b1);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0001, 1'b0);
        send_request(16'h8000, 1'b1);
    endtask

    task automatic test_field_extremes();
        settle();
        write_reg(CFG_RADIUS, 16'd31);
        write_reg(CFG_NORMALIZE, 16'd1);
        write_reg(CFG_RECIP, 16'hFFFF);
        send_request(16'hFFFF, 1'b0);
        send_request(16'hFFFF, 1'b1);
        settle();
        write_reg(CFG_RECIP, 16'd0);
        send_request(16'd40000, 1'b1);
        settle();
        write_reg(CFG_NORMALIZE, 16'd0);
        send_request(16'hFFFF, 1'b1);
        settle();
        write_reg(CFG_RADIUS, 16'd0);
        send_request(16'd12345, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b1);
    endtask

    task automatic test_radius_mid_line();
        settle();
        write_reg(CFG_RADIUS, 16'd2);
        send_request(16'd100, 1'b0);
        send_request(16'd65000, 1'b0);
        send_request(16'd7, 1'b0);
        settle();
        // new radius waits for the next line, scaling applies at once
        write_reg(CFG_RADIUS, 16'd7);
        write_reg(CFG_NORMALIZE, 16'd1);
        write_reg(CFG_RECIP, 16'd13107);
        send_request(16'd30000, 1'b0);
        send_request(16'd555, 1'b1);
        send_line(4);
    endtask

    task automatic test_long_line();
        settle();
        write_reg(CFG_RADIUS, 16'd4);
        write_reg(CFG_NORMALIZE, 16'd0);
        send_line(LONG_ITEMS);
        send_line(5);
    endtask

    task automatic test_random_lines();
        int phase;
        int sent;
        int len;
        int r;
        for (phase = 0; phase < 6; phase++)
        begin
            settle();
            r = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
            write_reg(CFG_RADIUS, CFG_DATA_W'(r));
            write_reg(CFG_NORMALIZE, CFG_DATA_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_RECIP, CFG_DATA_W'(65536 / (2 * r + 1)));
            else
                write_reg(CFG_RECIP, CFG_DATA_W'($urandom_range(0, 65535)));
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    len = $urandom_range(1, r + 1);
                    2:       len = $urandom_range(64, 72);
                    default: len = $urandom_range(1, 2 * r + 10);
                endcase
                send_line(len);
                sent += len;
            end
        end
    endtask

    initial
    begin
        fault_count = 0;
        burst_left = 0;
        line_pos = 0;
        line_r = RADIUS_RESET;
        edge_sample = '0;
        window_total = '0;
        shadow_radius = RADIUS_RESET;
        shadow_norm = 1'b0;
        shadow_recip = RECIP_RESET;
        foreach (line_history[i])
            line_history[i] = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_field_extremes();
        test_radius_mid_line();
        test_long_line();
        test_random_lines();
        settle();
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/lbsr_pkg.sv
design/lbsr_ring.sv
design/lbsr_front.sv
design/lbsr_accum.sv
design/lbsr_norm.sv
design/line_box_sum_replicate.sv
design/lbsr_checker.sv
tb/tb_top.sv
